### rtl/arpsm_pkg.sv
// ----------------------------------------------------------------------------
// ARP spoof monitor package
// Field widths, protocol constants, result codes and sequencer states.
// ----------------------------------------------------------------------------
package arpsm_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    localparam int HW_W    = 16;
    localparam int PROTO_W = 16;
    localparam int OP_W    = 16;
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int IDX_W   = 8;

    localparam int S_DATA_W = 224;
    localparam int M_DATA_W = 96;

    localparam logic [HW_W-1:0]    ETH_HW_TYPE = 16'h0001;
    localparam logic [PROTO_W-1:0] IPV4_PROTO  = 16'h0800;
    localparam logic [OP_W-1:0]    OP_REQUEST  = 16'h0001;

    typedef enum logic [2:0] {
        OUT_MATCH       = 3'd0,
        OUT_IP_CHANGED  = 3'd1,
        OUT_MAC_CHANGED = 3'd2,
        OUT_ADDED       = 3'd3,
        OUT_FULL        = 3'd4,
        OUT_IGNORED     = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

### rtl/arpsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module arpsm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/arp_spoof_monitor_top.sv
// An ignored packet gives its result in the cycle after it is accepted; otherwise
// the table walk reads one entry per cycle and stops at the first entry sharing the IP
// or the MAC; with no such entry the pair is added, or the table is reported full.
// Throughput: one item at a time; the walk on the single RAM read port and m_tready set it.
// Reset: the entry count and control state clear; table contents stay as they were.
// ----------------------------------------------------------------------------
// ARP spoof monitor top level
// Checks ARP headers against a learned table of IP-MAC bindings.
// ----------------------------------------------------------------------------
module arp_spoof_monitor_top #(
    parameter int MAX_ENTRIES = arpsm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // hw_type, proto_type, arp_opcode, frame_src_mac, sender_mac, sender_ip, target_mac
    input  logic [arpsm_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // mac_mismatch, unicast_request, table_outcome, entry_index, stored_ip,
    // stored_mac, is_request, two zero bits
    output logic [arpsm_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (AW > arpsm_pkg::IDX_W) ? AW : arpsm_pkg::IDX_W;
    localparam int IP_W  = arpsm_pkg::IP_W;
    localparam int MAC_W = arpsm_pkg::MAC_W;
    localparam int TW = IP_W + MAC_W;

    arpsm_pkg::state_t state_reg, state_next;

    logic                alert_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IP_W-1:0]     sip_reg, sip_next;
    logic [MAC_W-1:0]    smac_reg, smac_next;

    logic                  res_mism_reg, res_mism_next;
    logic                  res_uni_reg, res_uni_next;
    logic                  res_req_reg, res_req_next;
    arpsm_pkg::outcome_t   res_outcome_reg, res_outcome_next;
    logic [arpsm_pkg::IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [IP_W-1:0]       res_ip_reg, res_ip_next;
    logic [MAC_W-1:0]      res_mac_reg, res_mac_next;

    logic [arpsm_pkg::HW_W-1:0]    in_hw;
    logic [arpsm_pkg::PROTO_W-1:0] in_proto;
    logic [arpsm_pkg::OP_W-1:0]    in_op;
    logic [MAC_W-1:0]              in_fmac;
    logic [MAC_W-1:0]              in_smac;
    logic [IP_W-1:0]               in_sip;
    logic [MAC_W-1:0]              in_tmac;

    logic          wr_en;
    logic          rd_en;
    logic [TW-1:0] rd_data;
    logic          ip_eq;
    logic          mac_eq;
    logic          hit;
    logic          scan_done;
    logic          has_room;
    logic          pkt_valid;
    logic          pkt_req;
    logic [IW-1:0] hit_idx_ext;
    logic [IW-1:0] add_idx_ext;

    assign in_hw    = s_tdata[15:0];
    assign in_proto = s_tdata[31:16];
    assign in_op    = s_tdata[47:32];
    assign in_fmac  = s_tdata[95:48];
    assign in_smac  = s_tdata[143:96];
    assign in_sip   = s_tdata[175:144];
    assign in_tmac  = s_tdata[223:176];

    arpsm_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({smac_reg, sip_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign ip_eq     = (rd_data[IP_W-1:0] == sip_reg);
    assign mac_eq    = (rd_data[TW-1:IP_W] == smac_reg);
    assign hit       = cmp_valid_reg && (ip_eq || mac_eq);
    assign scan_done = !hit && (rd_ptr_reg == count_reg);
    assign has_room  = (count_reg < CW'(MAX_ENTRIES));
    assign pkt_valid = (in_hw == arpsm_pkg::ETH_HW_TYPE) && (in_proto == arpsm_pkg::IPV4_PROTO);
    assign pkt_req   = (in_op == arpsm_pkg::OP_REQUEST);
    assign hit_idx_ext = IW'(cmp_idx_reg);
    assign add_idx_ext = IW'(count_reg[AW-1:0]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            arpsm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pkt_valid ? arpsm_pkg::ST_SCAN : arpsm_pkg::ST_RESULT;
                end
            end
            arpsm_pkg::ST_SCAN: begin
                if (hit || scan_done) begin
                    state_next = arpsm_pkg::ST_RESULT;
                end
            end
            arpsm_pkg::ST_RESULT: begin
                if (m_tready) begin
                    state_next = arpsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = arpsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next       = count_reg;
        rd_ptr_next      = rd_ptr_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        sip_next         = sip_reg;
        smac_next        = smac_reg;
        res_mism_next    = res_mism_reg;
        res_uni_next     = res_uni_reg;
        res_req_next     = res_req_reg;
        res_outcome_next = res_outcome_reg;
        res_idx_next     = res_idx_reg;
        res_ip_next      = res_ip_reg;
        res_mac_next     = res_mac_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        case (state_reg)
            arpsm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    sip_next         = in_sip;
                    smac_next        = in_smac;
                    res_req_next     = pkt_valid && pkt_req;
                    res_mism_next    = pkt_valid && (in_fmac != in_smac);
                    res_uni_next     = pkt_valid && alert_reg && pkt_req && (in_tmac != '0);
                    res_outcome_next = arpsm_pkg::OUT_IGNORED;
                    res_idx_next     = '0;
                    res_ip_next      = '0;
                    res_mac_next     = '0;
                    rd_ptr_next      = '0;
                end
            end
            arpsm_pkg::ST_SCAN: begin
                if (hit) begin
                    if (ip_eq && mac_eq) begin
                        res_outcome_next = arpsm_pkg::OUT_MATCH;
                    end else if (mac_eq) begin
                        res_outcome_next = arpsm_pkg::OUT_IP_CHANGED;
                    end else begin
                        res_outcome_next = arpsm_pkg::OUT_MAC_CHANGED;
                    end
                    res_idx_next = hit_idx_ext[arpsm_pkg::IDX_W-1:0];
                    res_ip_next  = rd_data[IP_W-1:0];
                    res_mac_next = rd_data[TW-1:IP_W];
                end else if (scan_done) begin
                    if (has_room) begin
                        wr_en            = 1'b1;
                        count_next       = count_reg + CW'(1);
                        res_outcome_next = arpsm_pkg::OUT_ADDED;
                        res_idx_next     = add_idx_ext[arpsm_pkg::IDX_W-1:0];
                    end else begin
                        res_outcome_next = arpsm_pkg::OUT_FULL;
                    end
                end else begin
                    rd_en          = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_ptr_reg[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= arpsm_pkg::ST_IDLE;
            alert_reg     <= 1'b0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_valid && cfg_ready) begin
                alert_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg     <= cmp_idx_next;
        sip_reg         <= sip_next;
        smac_reg        <= smac_next;
        res_mism_reg    <= res_mism_next;
        res_uni_reg     <= res_uni_next;
        res_req_reg     <= res_req_next;
        res_outcome_reg <= res_outcome_next;
        res_idx_reg     <= res_idx_next;
        res_ip_reg      <= res_ip_next;
        res_mac_reg     <= res_mac_next;
    end

    assign s_tready  = (state_reg == arpsm_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == arpsm_pkg::ST_RESULT);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {2'b00, res_req_reg, res_mac_reg, res_ip_reg, res_idx_reg,
                        res_outcome_reg, res_uni_reg, res_mism_reg};

endmodule

### rtl/arpsm_checker.sv
// ----------------------------------------------------------------------------
// ARP spoof monitor checker
// Port-level assertions on handover between input and result channels.
// ----------------------------------------------------------------------------
module arpsm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [arpsm_pkg::M_DATA_W-1:0] m_tdata
);

    logic s_fire;
    logic m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input still ready after an item was accepted");

    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |=> (s_tready && !m_tvalid))
        else $error("block not idle after its result was taken");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_unicast_is_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> m_tdata[93])
        else $error("unicast flag on a result that is not a request");

endmodule

bind arp_spoof_monitor_top arpsm_checker u_arpsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP spoof monitor testbench
// Streams ARP header items into the monitor and checks every verdict against
// an in-bench copy of the IP-MAC binding table. A directed opening covers the
// ignored, added, match, IP-changed and MAC-changed cases and the unicast
// alert. Random phases then fill the table past its capacity under varying
// backpressure and alert settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int ITEMS_PER_PASS = 190;
    localparam int NUM_PASSES     = 8;
    localparam int MAX_PRINTED    = 50;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int HW_W    = arpsm_pkg::HW_W;
    localparam int PROTO_W = arpsm_pkg::PROTO_W;
    localparam int OP_W    = arpsm_pkg::OP_W;
    localparam int MAC_W   = arpsm_pkg::MAC_W;
    localparam int IP_W    = arpsm_pkg::IP_W;
    localparam int IDX_W   = arpsm_pkg::IDX_W;
    localparam int N_ENT   = arpsm_pkg::MAX_ENTRIES_DEF;

    typedef struct packed {
        logic [MAC_W-1:0]   target_mac;
        logic [IP_W-1:0]    sender_ip;
        logic [MAC_W-1:0]   sender_mac;
        logic [MAC_W-1:0]   frame_src_mac;
        logic [OP_W-1:0]    arp_opcode;
        logic [PROTO_W-1:0] proto_type;
        logic [HW_W-1:0]    hw_type;
    } arp_hdr_t;

    typedef struct packed {
        logic [1:0]          pad;
        logic                is_request;
        logic [MAC_W-1:0]    stored_mac;
        logic [IP_W-1:0]     stored_ip;
        logic [IDX_W-1:0]    entry_index;
        arpsm_pkg::outcome_t table_outcome;
        logic                unicast_request;
        logic                mac_mismatch;
    } arp_verdict_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [arpsm_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [arpsm_pkg::M_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_data = 1'b0;

    arp_hdr_t     pending_headers[$];
    arp_verdict_t expected_verdicts[$];
    bit           alert_writes[$];

    logic [IP_W-1:0]  learned_ip[N_ENT];
    logic [MAC_W-1:0] learned_mac[N_ENT];
    int               learned_count = 0;
    bit               alert_enabled = 1'b0;

    logic [IP_W-1:0]  pool_ip[$];
    logic [MAC_W-1:0] pool_mac[$];

    int idle_mode = IDLE_NONE;
    int fail_count = 0;
    int cycle_count = 0;

    arp_spoof_monitor_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic flag_error(string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    function automatic logic [MAC_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic bit sender_pauses();
        if (idle_mode == IDLE_SENDER) begin
            return $urandom_range(99) < 56;
        end else if (idle_mode == IDLE_BOTH) begin
            return $urandom_range(99) < 9;
        end
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (idle_mode == IDLE_RECEIVER) begin
            return $urandom_range(99) < 56;
        end else if (idle_mode == IDLE_BOTH) begin
            return $urandom_range(99) < 9;
        end
        return 1'b0;
    endfunction

    // Walks the learned bindings in entry order, as the block does, and
    // appends the pair when no entry shares either address and there is room.
    function automatic arp_verdict_t predict_verdict(arp_hdr_t h);
        arp_verdict_t v;
        bit hit;
        bit ip_eq;
        bit mac_eq;
        v = '0;
        v.table_outcome = arpsm_pkg::OUT_IGNORED;
        hit = 1'b0;
        if (h.hw_type == arpsm_pkg::ETH_HW_TYPE && h.proto_type == arpsm_pkg::IPV4_PROTO) begin
            v.is_request = (h.arp_opcode == arpsm_pkg::OP_REQUEST);
            v.mac_mismatch = (h.frame_src_mac != h.sender_mac);
            v.unicast_request = alert_enabled && v.is_request && (h.target_mac != '0);
            for (int j = 0; j < learned_count && !hit; j++) begin
                ip_eq = (learned_ip[j] == h.sender_ip);
                mac_eq = (learned_mac[j] == h.sender_mac);
                if (ip_eq || mac_eq) begin
                    hit = 1'b1;
                    if (ip_eq && mac_eq) begin
                        v.table_outcome = arpsm_pkg::OUT_MATCH;
                    end else if (mac_eq) begin
                        v.table_outcome = arpsm_pkg::OUT_IP_CHANGED;
                    end else begin
                        v.table_outcome = arpsm_pkg::OUT_MAC_CHANGED;
                    end
                    v.entry_index = IDX_W'(j);
                    v.stored_ip = learned_ip[j];
                    v.stored_mac = learned_mac[j];
                end
            end
            if (!hit) begin
                if (learned_count < N_ENT) begin
                    learned_ip[learned_count] = h.sender_ip;
                    learned_mac[learned_count] = h.sender_mac;
                    v.entry_index = IDX_W'(learned_count);
                    v.table_outcome = arpsm_pkg::OUT_ADDED;
                    learned_count++;
                end else begin
                    v.table_outcome = arpsm_pkg::OUT_FULL;
                end
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_verdicts.push_back(predict_verdict(arp_hdr_t'(s_tdata)));
            end
            if (pending_headers.size() != 0 && !sender_pauses()) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_headers.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid || cfg_ready) begin
            if (cfg_valid) begin
                alert_enabled = cfg_data;
            end
            if (alert_writes.size() != 0) begin
                cfg_valid <= 1'b1;
                cfg_data <= alert_writes.pop_front();
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        arp_verdict_t got;
        arp_verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_verdicts.size() == 0) begin
                    flag_error($sformatf("unexpected result item %h", m_tdata));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.mac_mismatch !== want.mac_mismatch)
                        flag_error($sformatf("mac_mismatch %b, want %b",
                                             got.mac_mismatch, want.mac_mismatch));
                    if (got.unicast_request !== want.unicast_request)
                        flag_error($sformatf("unicast_request %b, want %b",
                                             got.unicast_request, want.unicast_request));
                    if (got.table_outcome !== want.table_outcome)
                        flag_error($sformatf("table_outcome %0d, want %0d",
                                             got.table_outcome, want.table_outcome));
                    if (got.entry_index !== want.entry_index)
                        flag_error($sformatf("entry_index %0d, want %0d",
                                             got.entry_index, want.entry_index));
                    if (got.stored_ip !== want.stored_ip)
                        flag_error($sformatf("stored_ip %h, want %h",
                                             got.stored_ip, want.stored_ip));
                    if (got.stored_mac !== want.stored_mac)
                        flag_error($sformatf("stored_mac %h, want %h",
                                             got.stored_mac, want.stored_mac));
                    if (got.is_request !== want.is_request)
                        flag_error($sformatf("is_request %b, want %b",
                                             got.is_request, want.is_request));
                    if (got.pad !== 2'b00)
                        flag_error($sformatf("padding bits %b, want 00", got.pad));
                end
            end
            m_tready <= !receiver_stalls();
        end
    end

    function automatic arp_hdr_t make_hdr(logic [HW_W-1:0] hw, logic [PROTO_W-1:0] proto,
                                          logic [OP_W-1:0] op, logic [MAC_W-1:0] fmac,
                                          logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                          logic [MAC_W-1:0] tmac);
        arp_hdr_t h;
        h.hw_type = hw;
        h.proto_type = proto;
        h.arp_opcode = op;
        h.frame_src_mac = fmac;
        h.sender_mac = smac;
        h.sender_ip = sip;
        h.target_mac = tmac;
        return h;
    endfunction

    // Packets that the monitor must skip: random headers and headers with only
    // one of the hardware and protocol types right.
    function automatic arp_hdr_t make_foreign_packet();
        arp_hdr_t h;
        int pick;
        h = make_hdr(16'($urandom), 16'($urandom), 16'($urandom), rand48(), rand48(),
                     32'($urandom), rand48());
        pick = $urandom_range(3);
        if (pick == 0) begin
            h.hw_type = arpsm_pkg::ETH_HW_TYPE;
        end else if (pick == 1) begin
            h.proto_type = arpsm_pkg::IPV4_PROTO;
        end
        return h;
    endfunction

    // Ethernet/IPv4 packets whose addresses are mostly drawn from pairs sent
    // earlier, so that matches and both kinds of conflict are frequent.
    function automatic arp_hdr_t make_binding_packet();
        arp_hdr_t h;
        int pick;
        int k;
        pick = $urandom_range(99);
        h = make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                     pick < 55 ? arpsm_pkg::OP_REQUEST : (pick < 90 ? 16'd2 : 16'($urandom)),
                     '0, rand48(), 32'($urandom),
                     $urandom_range(1) ? '0 : rand48());
        pick = $urandom_range(99);
        if (pool_ip.size() == 0 || pick < 35) begin
            pool_ip.push_back(h.sender_ip);
            pool_mac.push_back(h.sender_mac);
        end else begin
            k = $urandom_range(pool_ip.size() - 1);
            if (pick < 65) begin
                h.sender_ip = pool_ip[k];
                h.sender_mac = pool_mac[k];
            end else if (pick < 80) begin
                h.sender_mac = pool_mac[k];
            end else if (pick < 95) begin
                h.sender_ip = pool_ip[k];
            end else begin
                h.sender_ip = pool_ip[k];
                h.sender_mac = pool_mac[$urandom_range(pool_mac.size() - 1)];
            end
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            h.frame_src_mac = h.sender_mac;
        end else if (pick < 90) begin
            h.frame_src_mac = h.sender_mac ^ (48'd1 << $urandom_range(MAC_W - 1));
        end else begin
            h.frame_src_mac = rand48();
        end
        return h;
    endfunction

    task automatic wait_idle();
        while (pending_headers.size() != 0 || s_tvalid || expected_verdicts.size() != 0
               || alert_writes.size() != 0 || cfg_valid) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int made;
        logic [MAC_W-1:0] ones48;
        ones48 = '1;
        repeat (5) @(negedge aclk);

        pending_headers.push_back(make_hdr('1, arpsm_pkg::IPV4_PROTO, '1, ones48, ones48,
                                           '1, ones48));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, '1, arpsm_pkg::OP_REQUEST,
                                           '0, '0, '0, '0));
        pending_headers.push_back(make_hdr('0, '0, '0, '0, '0, '0, '0));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           arpsm_pkg::OP_REQUEST, '0, '0, '0, '0));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           16'd2, '0, '0, '0, '0));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           arpsm_pkg::OP_REQUEST, '0, ones48, '1, ones48));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           '1, ones48, ones48, 32'h0a00_0001, '0));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           16'd0, 48'h0200_0000_0001, 48'h0200_0000_0001,
                                           '1, '0));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           16'd2, 48'h0200_0000_0002, 48'h0200_0000_0002,
                                           32'hc0a8_0101, 48'h0200_0000_0001));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           arpsm_pkg::OP_REQUEST,
                                           48'h0200_0000_0002, 48'h0200_0000_0002,
                                           32'hc0a8_0101, '0));
        wait_idle();

        alert_writes.push_back(1'b1);
        wait_idle();
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           arpsm_pkg::OP_REQUEST,
                                           48'h0200_0000_0003, 48'h0200_0000_0003,
                                           32'hc0a8_0102, ones48));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           arpsm_pkg::OP_REQUEST,
                                           48'h0200_0000_0003, 48'h0200_0000_0003,
                                           32'hc0a8_0102, 48'h0000_0000_0001));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           arpsm_pkg::OP_REQUEST, '0,
                                           48'h0200_0000_0003, 32'hc0a8_0102, '0));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, arpsm_pkg::IPV4_PROTO,
                                           16'd2, '0,
                                           48'h0200_0000_0003, 32'hc0a8_0102, ones48));
        pending_headers.push_back(make_hdr(arpsm_pkg::ETH_HW_TYPE, 16'h0806,
                                           arpsm_pkg::OP_REQUEST, '0,
                                           48'h0200_0000_0003, 32'hc0a8_0102, ones48));
        wait_idle();

        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            idle_mode = pass % 4;
            alert_writes.push_back(pass % 2 == 0 ? 1'b0 : 1'b1);
            wait_idle();
            made = 0;
            while (made < ITEMS_PER_PASS) begin
                if ($urandom_range(99) < 10) begin
                    pending_headers.push_back(make_foreign_packet());
                end else begin
                    pending_headers.push_back(make_binding_packet());
                    made++;
                end
            end
            wait_idle();
        end

        repeat (N_ENT + 50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/arpsm_pkg.sv
rtl/arpsm_ram.sv
rtl/arp_spoof_monitor_top.sv
rtl/arpsm_checker.sv
dv/tb_top.sv
